// File: rtl/nstdl_pkg.sv
package nstdl_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned NameW  = 4;
  localparam int unsigned TblSize = 16;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_LOOKUP   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SEND
  } nstdl_state_e;

  typedef enum logic [1:0] {
    SEL_REG,
    SEL_LOOK,
    SEL_DRAIN
  } nstdl_sel_e;

  typedef struct packed {
    logic       load;
    logic       tbl_wr;
    logic       dec_left;
    logic       push;
    logic       pop;
    logic       emit;
    nstdl_sel_e sel;
    logic       last;
  } nstdl_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic started;
    logic releasing;
    logic fifo_full;
    logic fifo_empty;
    logic out_free;
  } nstdl_sts_t;

endpackage

// File: rtl/name_table_with_deferred_lookup.sv
// Name table: maps a 4-bit name to the 16-bit task id that registered it.
// A register word (tuser 0) stores sender_id and replies with it; a lookup
// word (tuser 1) replies with the stored id. Until NAME_COUNT registrations
// have arrived, lookups are queued in a PENDING_DEPTH-entry FIFO memory
// (dropped when it is full); the registration that completes the count
// replies first and then releases the queued lookups in order, the last
// reply flagged by tlast. A word is accepted in IDLE and executed against
// the table in EXEC; a releasing registration then passes each queued
// lookup through a registered FIFO memory read (READ) and a table read into
// the output register (SEND). Output backpressure stalls the reply steps.
module name_table_with_deferred_lookup
  import nstdl_pkg::*;
#(
  parameter int unsigned NAME_COUNT    = 16,
  parameter int unsigned PENDING_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // sender_id[15:0], name_index[19:16], zero[23:20]
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // reply_to[15:0], reply_value[31:16]
  output logic        m_axis_tlast
);

  nstdl_cmd_t cmd;
  nstdl_sts_t sts;

  nstdl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nstdl_dp #(
    .NAME_COUNT    (NAME_COUNT),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (s_axis_tuser),
    .sender_i      (s_axis_tdata[15:0]),
    .name_i        (s_axis_tdata[19:16]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .reply_to_o    (m_axis_tdata[15:0]),
    .reply_value_o (m_axis_tdata[31:16]),
    .last_o        (m_axis_tlast)
  );

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !sts.fifo_full)
    else $error("push into full queue");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("reply overwrites pending output word");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word taken while one is in work");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !sts.fifo_empty)
    else $error("pop from empty queue");

endmodule

// File: rtl/nstdl_ctrl.sv
module nstdl_ctrl
  import nstdl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  nstdl_sts_t sts_i,
  output nstdl_cmd_t cmd_o
);

  nstdl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.is_lookup) begin
          if (!sts_i.started || sts_i.out_free) state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          state_d = (!sts_i.started && sts_i.releasing) ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: state_d = ST_SEND;
      ST_SEND: begin
        if (sts_i.out_free) state_d = sts_i.fifo_empty ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = SEL_REG;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC: begin
        if (sts_i.is_lookup) begin
          if (sts_i.started) begin
            cmd_o.emit = sts_i.out_free;
            cmd_o.sel  = SEL_LOOK;
            cmd_o.last = 1'b1;
          end else begin
            cmd_o.push = !sts_i.fifo_full;
          end
        end else if (sts_i.out_free) begin
          cmd_o.tbl_wr   = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = SEL_REG;
          cmd_o.dec_left = !sts_i.started;
          cmd_o.last     = sts_i.started || !sts_i.releasing;
        end
      end
      ST_READ: cmd_o.pop = 1'b1;
      ST_SEND: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.sel  = SEL_DRAIN;
        cmd_o.last = sts_i.fifo_empty;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: rtl/nstdl_dp.sv
module nstdl_dp
  import nstdl_pkg::*;
#(
  parameter int unsigned NAME_COUNT    = 16,
  parameter int unsigned PENDING_DEPTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nstdl_cmd_t       cmd_i,
  output nstdl_sts_t       sts_o,
  input  logic             op_i,
  input  logic [IdW-1:0]   sender_i,
  input  logic [NameW-1:0] name_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IdW-1:0]   reply_to_o,
  output logic [IdW-1:0]   reply_value_o,
  output logic             last_o
);

  localparam int unsigned LeftW = $clog2(NAME_COUNT + 1);
  localparam int unsigned CntW  = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned PtrW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  logic             op_q;
  logic [IdW-1:0]   sender_q;
  logic [NameW-1:0] name_q;

  logic [IdW-1:0]   tbl_q [TblSize];
  logic [LeftW-1:0] left_q;
  logic [CntW-1:0]  count_q;
  logic [PtrW-1:0]  head_q, tail_q;

  logic [IdW+NameW-1:0] mem [PENDING_DEPTH];
  logic [IdW+NameW-1:0] rd_q;

  logic             out_valid_q;
  logic [IdW-1:0]   reply_to_q, reply_value_q;
  logic             last_q;

  logic [NameW-1:0] rd_name;
  logic [IdW-1:0]   rd_client;
  logic [NameW-1:0] tbl_addr;
  logic [IdW-1:0]   tbl_rd;
  logic [IdW-1:0]   to_d, value_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(PENDING_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign rd_client = rd_q[IdW-1:0];
  assign rd_name   = rd_q[IdW+NameW-1:IdW];
  assign tbl_addr  = (cmd_i.sel == SEL_DRAIN) ? rd_name : name_q;
  assign tbl_rd    = tbl_q[tbl_addr];

  assign sts_o.is_lookup  = (op_q == OP_LOOKUP);
  assign sts_o.started    = (left_q == '0);
  assign sts_o.releasing  = (left_q == LeftW'(1)) && (count_q != '0);
  assign sts_o.fifo_full  = (count_q == CntW'(PENDING_DEPTH));
  assign sts_o.fifo_empty = (count_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      sender_q <= sender_i;
      name_q   <= name_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TblSize; i++) tbl_q[i] <= '0;
    end else if (cmd_i.tbl_wr) begin
      tbl_q[name_q] <= sender_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= LeftW'(NAME_COUNT);
      count_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
    end else begin
      if (cmd_i.dec_left) left_q <= left_q - LeftW'(1);
      if (cmd_i.push) begin
        tail_q  <= ptr_next(tail_q);
        count_q <= count_q + CntW'(1);
      end else if (cmd_i.pop) begin
        head_q  <= ptr_next(head_q);
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem[tail_q] <= {name_q, sender_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) rd_q <= mem[head_q];
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_LOOK: begin
        to_d    = sender_q;
        value_d = tbl_rd;
      end
      SEL_DRAIN: begin
        to_d    = rd_client;
        value_d = tbl_rd;
      end
      default: begin
        to_d    = sender_q;
        value_d = sender_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      reply_to_q    <= to_d;
      reply_value_q <= value_d;
      last_q        <= cmd_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign reply_to_o    = reply_to_q;
  assign reply_value_o = reply_value_q;
  assign last_o        = last_q;

endmodule

// File: bench/tb.sv
module tb
  import nstdl_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NAME_COUNT    = 16;
  localparam int unsigned PENDING_DEPTH = 32;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned PHASE_WORDS   = 95;
  localparam int unsigned DROP_TARGET   = 6;

  typedef struct packed {
    logic             op;
    logic [IdW-1:0]   sender;
    logic [NameW-1:0] name;
  } request_t;

  typedef struct packed {
    logic [IdW-1:0] dest;
    logic [IdW-1:0] value;
    logic           last;
  } reply_t;

  typedef struct {
    request_t req;
    bit       typed;
    reply_t   reply;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // sender_id[15:0], name_index[19:16], zero[23:20]
  logic        s_axis_tuser = 1'b0; // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // reply_to[15:0], reply_value[31:16]
  logic        m_axis_tlast;

  name_table_with_deferred_lookup #(
    .NAME_COUNT   (NAME_COUNT),
    .PENDING_DEPTH(PENDING_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [IdW-1:0] shadow_ids [TblSize];
  request_t       shadow_waiting[$];
  int unsigned    shadow_left = NAME_COUNT;
  reply_t         fresh_replies[$];
  reply_t         awaited_replies[$];
  dir_row_t       dir_rows[$];

  bit          row_typed = 1'b0;
  reply_t      row_reply = '0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  int unsigned errors = 0;
  int unsigned requests_taken = 0;
  int unsigned replies_checked = 0;
  int unsigned deferred_lookups = 0;
  int unsigned dropped_lookups = 0;
  int unsigned released_replies = 0;

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void predict_replies(input request_t req);
    reply_t   r;
    request_t q;
    fresh_replies.delete();
    if (req.op == OP_REGISTER) begin
      shadow_ids[req.name] = req.sender;
      r = '{dest: req.sender, value: req.sender, last: 1'b1};
      if (shadow_left == 0) begin
        fresh_replies.push_back(r);
        return;
      end
      shadow_left--;
      if (shadow_left != 0 || shadow_waiting.size() == 0) begin
        fresh_replies.push_back(r);
        return;
      end
      r.last = 1'b0;
      fresh_replies.push_back(r);
      while (shadow_waiting.size() != 0) begin
        q = shadow_waiting.pop_front();
        r = '{dest: q.sender, value: shadow_ids[q.name], last: shadow_waiting.size() == 0};
        fresh_replies.push_back(r);
        released_replies++;
      end
    end else if (shadow_left == 0) begin
      fresh_replies.push_back('{dest: req.sender, value: shadow_ids[req.name], last: 1'b1});
    end else if (shadow_waiting.size() < PENDING_DEPTH) begin
      shadow_waiting.push_back(req);
      deferred_lookups++;
    end else begin
      dropped_lookups++;
    end
  endfunction

  task automatic take_request();
    request_t req;
    req = '{op: s_axis_tuser, sender: s_axis_tdata[15:0], name: s_axis_tdata[19:16]};
    predict_replies(req);
    if (row_typed) begin
      awaited_replies.push_back(row_reply);
    end else begin
      foreach (fresh_replies[i]) awaited_replies.push_back(fresh_replies[i]);
    end
    requests_taken++;
  endtask

  task automatic check_reply();
    reply_t want;
    if (awaited_replies.size() == 0) begin
      flag_error($sformatf("reply to %h value %h with none awaited",
                           m_axis_tdata[15:0], m_axis_tdata[31:16]));
      return;
    end
    want = awaited_replies.pop_front();
    if (m_axis_tdata[15:0] !== want.dest)
      flag_error($sformatf("reply_to %h, want %h", m_axis_tdata[15:0], want.dest));
    if (m_axis_tdata[31:16] !== want.value)
      flag_error($sformatf("reply_value %h, want %h", m_axis_tdata[31:16], want.value));
    if (m_axis_tlast !== want.last)
      flag_error($sformatf("last_reply %b, want %b", m_axis_tlast, want.last));
    replies_checked++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) take_request();
      if (m_axis_tvalid && m_axis_tready) check_reply();
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR at %0t: no word moved for %0d cycles", $realtime, idle_cycles);
      $display("name_table_with_deferred_lookup verification failed");
      $finish;
    end
  end

  // hold off the reply side for a long stretch on request, else stall at random
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void add_row(input logic op, input logic [IdW-1:0] sender,
                                  input logic [NameW-1:0] name, input bit typed,
                                  input reply_t reply);
    dir_row_t row;
    row.req   = '{op: op, sender: sender, name: name};
    row.typed = typed;
    row.reply = reply;
    dir_rows.push_back(row);
  endfunction

  function automatic request_t random_request(input logic op);
    request_t req;
    req.op     = op;
    req.sender = IdW'($urandom);
    req.name   = NameW'($urandom_range(TblSize - 1));
    return req;
  endfunction

  function automatic logic pick_op();
    return ($urandom_range(1) == 0) ? OP_REGISTER : OP_LOOKUP;
  endfunction

  task automatic send_word(input request_t req, input bit typed, input reply_t reply);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, req.name, req.sender};
    s_axis_tuser  <= req.op;
    row_typed = typed;
    row_reply = reply;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_for_replies();
    s_axis_tvalid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  int unsigned phase_send[4]  = '{0, 51, 0, 12};
  int unsigned phase_stall[4] = '{0, 0, 51, 12};

  initial begin
    foreach (shadow_ids[i]) shadow_ids[i] = '0;

    // start-up: queue lookups, register with extreme ids, overwrite a queued name
    add_row(OP_LOOKUP,   16'hFFFF, 4'hF, 1'b0, '0);
    add_row(OP_LOOKUP,   16'h0000, 4'h0, 1'b0, '0);
    add_row(OP_REGISTER, 16'hFFFF, 4'hF, 1'b1, '{16'hFFFF, 16'hFFFF, 1'b1});
    add_row(OP_REGISTER, 16'h0000, 4'h0, 1'b1, '{16'h0000, 16'h0000, 1'b1});
    add_row(OP_LOOKUP,   16'h8000, 4'hF, 1'b0, '0);
    add_row(OP_LOOKUP,   16'h0001, 4'h8, 1'b0, '0);
    add_row(OP_REGISTER, 16'h0001, 4'h1, 1'b1, '{16'h0001, 16'h0001, 1'b1});
    add_row(OP_REGISTER, 16'h8000, 4'h8, 1'b1, '{16'h8000, 16'h8000, 1'b1});
    add_row(OP_REGISTER, 16'hA5A5, 4'h5, 1'b0, '0);
    add_row(OP_REGISTER, 16'h5A5A, 4'hA, 1'b0, '0);
    add_row(OP_LOOKUP,   16'h7FFF, 4'h5, 1'b0, '0);
    add_row(OP_REGISTER, 16'h1234, 4'hF, 1'b0, '0);
    add_row(OP_REGISTER, 16'h0F0F, 4'h2, 1'b0, '0);
    add_row(OP_REGISTER, 16'hF0F0, 4'h3, 1'b0, '0);
    add_row(OP_LOOKUP,   16'hC3C3, 4'hE, 1'b0, '0);
    add_row(OP_REGISTER, 16'h3C3C, 4'h4, 1'b0, '0);
    add_row(OP_REGISTER, 16'h00FF, 4'h6, 1'b0, '0);
    add_row(OP_REGISTER, 16'hFF00, 4'h7, 1'b0, '0);
    add_row(OP_LOOKUP,   16'h4321, 4'h7, 1'b0, '0);
    add_row(OP_REGISTER, 16'hBEEF, 4'h9, 1'b0, '0);
    add_row(OP_REGISTER, 16'hCAFE, 4'hB, 1'b0, '0);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_word(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].reply);

    // fill the pending queue past full, keeping one registration back for the release
    send_idle_pct = 12;
    stall_pct     = 12;
    while (dropped_lookups < DROP_TARGET) begin
      if (shadow_left > 1 && shadow_waiting.size() >= PENDING_DEPTH / 2) begin
        send_word(random_request(OP_REGISTER), 1'b0, '0);
      end else begin
        send_word(random_request(OP_LOOKUP), 1'b0, '0);
      end
    end
    wait_for_replies();

    // release under a long receiver hold-off while the sender keeps offering words
    @(posedge clk_i);
    hold_req = 1'b1;
    @(negedge clk_i);
    send_idle_pct = 0;
    stall_pct     = 0;
    send_word(random_request(OP_REGISTER), 1'b0, '0);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_send[p];
      stall_pct     = phase_stall[p];
      repeat (PHASE_WORDS) send_word(random_request(pick_op()), 1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    stall_pct = 0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (awaited_replies.size() != 0)
      flag_error($sformatf("%0d replies never arrived", awaited_replies.size()));

    $display("covered %0d requests and %0d checked replies: %0d lookups deferred,",
             requests_taken, replies_checked, deferred_lookups);
    $display("%0d dropped on a full queue, %0d released by the final registration",
             dropped_lookups, released_replies);
    if (errors == 0) begin
      $display("name_table_with_deferred_lookup verification clean");
    end else begin
      $display("name_table_with_deferred_lookup verification failed");
    end
    $finish;
  end

endmodule
